FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on the rising edge
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

FILE: design/bpl_pkg.sv
// ----------------------------------------------------------------------------
// bpl_pkg
// types and constants for the bounded positional list
// ----------------------------------------------------------------------------
package bpl_pkg;

    localparam int DEPTH   = 16;
    localparam int WIDTH   = 32;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMD_W   = 3;
    localparam int POS_W   = 5;
    localparam int LIMIT_W = 5;
    localparam int ERR_W   = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_ERASE  = 3'd1,
        CMD_PUSH   = 3'd2,
        CMD_POP    = 3'd3,
        CMD_READ   = 3'd4,
        CMD_CLEAR  = 3'd5
    } t_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_RANGE = 2'd2,
        ERR_EMPTY = 2'd3
    } t_err;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] index;
        logic [WIDTH-1:0] value;
    } t_request;

    typedef struct packed {
        logic [WIDTH-1:0] read_value;
        logic [WIDTH-1:0] front_value;
        logic [WIDTH-1:0] back_value;
        logic [CNT_W-1:0] count;
        logic             is_empty;
        logic [ERR_W-1:0] error;
    } t_result;

    // broadcast to every cell of the row
    typedef struct packed {
        logic             ins;
        logic             era;
        logic [POS_W-1:0] pos;
        logic [WIDTH-1:0] value;
        logic [POS_W-1:0] rd_idx;
        logic             back_en;
        logic [IDX_W-1:0] back_idx;
    } t_cell_ctl;

endpackage

FILE: design/bpl_cell.sv
// ----------------------------------------------------------------------------
// bpl_cell
// one list entry: shifts with its neighbors and feeds the read and back chains
// ----------------------------------------------------------------------------
module bpl_cell (
    input  logic                         i_clk,
    input  bpl_pkg::t_cell_ctl           i_ctl,
    input  logic [bpl_pkg::IDX_W-1:0]    i_cell_idx,
    input  logic [bpl_pkg::WIDTH-1:0]    i_left,
    input  logic [bpl_pkg::WIDTH-1:0]    i_right,
    input  logic [bpl_pkg::WIDTH-1:0]    i_rd_chain,
    input  logic [bpl_pkg::WIDTH-1:0]    i_back_chain,
    output logic [bpl_pkg::WIDTH-1:0]    o_data,
    output logic [bpl_pkg::WIDTH-1:0]    o_rd_chain,
    output logic [bpl_pkg::WIDTH-1:0]    o_back_chain
);
    import bpl_pkg::*;

    logic [WIDTH-1:0] r_data;
    logic [WIDTH-1:0] n_data;
    logic [POS_W-1:0] w_me;
    logic             w_rd_hit;
    logic             w_back_hit;

    assign w_me = POS_W'(i_cell_idx);

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (w_me > i_ctl.pos) begin
                n_data = i_left;
            end else if (w_me == i_ctl.pos) begin
                n_data = i_ctl.value;
            end
        end else if (i_ctl.era) begin
            if (w_me >= i_ctl.pos) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign w_rd_hit     = (w_me == i_ctl.rd_idx);
    assign w_back_hit   = i_ctl.back_en && (i_cell_idx == i_ctl.back_idx);
    assign o_data       = r_data;
    assign o_rd_chain   = i_rd_chain | (w_rd_hit ? r_data : '0);
    assign o_back_chain = i_back_chain | (w_back_hit ? r_data : '0);

endmodule

FILE: design/bounded_positional_list.sv
// ----------------------------------------------------------------------------
// bounded_positional_list
// fixed-capacity ordered list built as a row of shifting entry cells
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  request   in         start & !busy         i_cmd (t_request)
//  result    out        o_done, one cycle     o_result (t_result)
//  config    in         i_cfg_we              i_cfg_data (capacity limit)
//
//  one request per cycle; its result appears in the cycle after acceptance
//  all entries shift in the same cycle on an insert or erase
//  busy stays low: the row of cells never holds off a request
//  synchronous reset empties the list and sets the limit to 16
//  entry contents are not cleared; only the count defines what is valid
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_positional_list (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bpl_pkg::t_request             i_cmd,
    input  logic                          i_cfg_we,
    input  logic [bpl_pkg::LIMIT_W-1:0]   i_cfg_data,
    output logic                          o_done,
    output bpl_pkg::t_result              o_result
);
    import bpl_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [LIMIT_W-1:0] r_limit;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_done;
    logic [WIDTH-1:0]   r_rd;
    logic [WIDTH-1:0]   n_rd;
    t_err               r_err;
    t_err               n_err;

    logic               w_accept;
    logic [CNT_W-1:0]   w_limit;
    logic               w_full;
    logic [POS_W-1:0]   w_count_pos;
    t_cell_ctl          w_ctl;

    logic [WIDTH-1:0]   w_data  [DEPTH];
    logic [WIDTH-1:0]   w_rd    [DEPTH+1];
    logic [WIDTH-1:0]   w_back  [DEPTH+1];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // a limit above the depth acts as the depth
    assign w_limit     = (CNT_W'(r_limit) > DEPTH_C) ? DEPTH_C : CNT_W'(r_limit);
    assign w_full      = (r_count >= w_limit) || (r_count >= DEPTH_C);
    assign w_count_pos = POS_W'(r_count);

    always_comb begin
        n_count        = r_count;
        n_err          = ERR_OK;
        n_rd           = '0;
        w_ctl.ins      = 1'b0;
        w_ctl.era      = 1'b0;
        w_ctl.pos      = i_cmd.index;
        w_ctl.value    = i_cmd.value;
        w_ctl.rd_idx   = i_cmd.index;
        w_ctl.back_en  = (r_count != '0);
        w_ctl.back_idx = IDX_W'(r_count - CNT_W'(1));
        case (i_cmd.command)
            CMD_INSERT, CMD_PUSH: begin
                if (i_cmd.command == CMD_PUSH) begin
                    w_ctl.pos = w_count_pos;
                end
                if (w_full) begin
                    n_err = ERR_FULL;
                end else if (w_ctl.pos > w_count_pos) begin
                    n_err = ERR_RANGE;
                end else begin
                    w_ctl.ins = w_accept;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            CMD_ERASE: begin
                if (r_count == '0) begin
                    n_err = ERR_EMPTY;
                end else if (i_cmd.index >= w_count_pos) begin
                    n_err = ERR_RANGE;
                end else begin
                    w_ctl.era = w_accept;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            CMD_POP: begin
                if (r_count == '0) begin
                    n_err = ERR_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_READ: begin
                if (i_cmd.index >= w_count_pos) begin
                    n_err = ERR_RANGE;
                end else begin
                    n_rd = w_rd[DEPTH];
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    assign w_rd[0]   = '0;
    assign w_back[0] = '0;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [WIDTH-1:0] w_left;
        logic [WIDTH-1:0] w_right;
        if (gi == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[gi+1];
        end
        bpl_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_cell_idx   (IDX_W'(gi)),
            .i_left       (w_left),
            .i_right      (w_right),
            .i_rd_chain   (w_rd[gi]),
            .i_back_chain (w_back[gi]),
            .o_data       (w_data[gi]),
            .o_rd_chain   (w_rd[gi+1]),
            .o_back_chain (w_back[gi+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_count <= '0;
            r_done  <= 1'b0;
            r_err   <= ERR_OK;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_done <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
                r_err   <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= n_rd;
        end
    end

    // front and back come from the cells after the update has landed
    assign o_done               = r_done;
    assign o_result.read_value  = r_rd;
    assign o_result.front_value = (r_count != '0) ? w_data[0] : '0;
    assign o_result.back_value  = w_back[DEPTH];
    assign o_result.count       = r_count;
    assign o_result.is_empty    = (r_count == '0);
    assign o_result.error       = r_err;

    `ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_C)
    `ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, w_accept, o_done)
    `ASSERT_SAME(a_fail_keeps_count, i_clk, i_rst_n,
        o_done && (r_err == ERR_FULL || r_err == ERR_RANGE || r_err == ERR_EMPTY),
        $stable(r_count))
    `ASSERT_NEXT(a_full_limit, i_clk, i_rst_n,
        w_accept && w_full && (i_cmd.command == CMD_INSERT || i_cmd.command == CMD_PUSH),
        r_err == ERR_FULL)

endmodule

FILE: sim/bpl_list_checker.sv
// ----------------------------------------------------------------------------
// bpl_list_checker
// watches the request, config and result channels of the bounded positional
// list, keeps a shadow copy of the list and compares each result field by field
// ----------------------------------------------------------------------------
module bpl_list_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  bpl_pkg::t_request           i_req,
    input  logic                        i_cfg_we,
    input  logic [bpl_pkg::LIMIT_W-1:0] i_cfg_data,
    input  logic                        i_done,
    input  bpl_pkg::t_result            i_result,
    output int                          o_fail_count,
    output int                          o_checked,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bpl_pkg::*;

    logic [WIDTH-1:0]   shadow_entries [DEPTH];
    int unsigned        shadow_count = 0;
    logic [LIMIT_W-1:0] shadow_limit = LIMIT_RESET;
    t_result            results_due [$];
    int                 fail_count = 0;
    int                 checked = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;

    // applies one request to the shadow list and returns the result it must give
    function automatic t_result apply_to_list(t_request req);
        t_result          res;
        t_err             err;
        int unsigned      room;
        int unsigned      pos;
        int unsigned      i;
        logic [WIDTH-1:0] rd;
        room = (shadow_limit > DEPTH) ? DEPTH : shadow_limit;
        pos  = req.index;
        err  = ERR_OK;
        rd   = '0;
        case (req.command)
            CMD_INSERT, CMD_PUSH: begin
                if (req.command == CMD_PUSH)
                    pos = shadow_count;
                // full wins over a bad index
                if (shadow_count >= room) begin
                    err = ERR_FULL;
                end else if (pos > shadow_count) begin
                    err = ERR_RANGE;
                end else begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[pos] = req.value;
                    shadow_count++;
                end
            end
            CMD_ERASE: begin
                if (shadow_count == 0) begin
                    err = ERR_EMPTY;
                end else if (pos >= shadow_count) begin
                    err = ERR_RANGE;
                end else begin
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                end
            end
            CMD_POP: begin
                if (shadow_count == 0)
                    err = ERR_EMPTY;
                else
                    shadow_count--;
            end
            CMD_READ: begin
                if (pos >= shadow_count)
                    err = ERR_RANGE;
                else
                    rd = shadow_entries[pos];
            end
            CMD_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
                // spare codes leave the list alone
            end
        endcase
        res.read_value  = rd;
        res.front_value = (shadow_count != 0) ? shadow_entries[0] : '0;
        res.back_value  = (shadow_count != 0) ? shadow_entries[shadow_count-1] : '0;
        res.count       = CNT_W'(shadow_count);
        res.is_empty    = (shadow_count == 0);
        res.error       = err;
        return res;
    endfunction

    task automatic check_field(string name, logic [WIDTH-1:0] want, logic [WIDTH-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            shadow_count = 0;
            shadow_limit = LIMIT_RESET;
            results_due.delete();
        end else begin
            // results first: a request taken on this edge is answered later
            if (i_done) begin
                if (results_due.size() == 0) begin
                    $error("result with no request waiting");
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    checked++;
                    check_field("read_value", want.read_value, i_result.read_value);
                    check_field("front_value", want.front_value, i_result.front_value);
                    check_field("back_value", want.back_value, i_result.back_value);
                    check_field("count", want.count, i_result.count);
                    check_field("is_empty", want.is_empty, i_result.is_empty);
                    check_field("error", want.error, i_result.error);
                end
            end
            // a request on this edge still sees the old limit
            if (i_start && !i_busy)
                results_due = {results_due, apply_to_list(i_req)};
            if (i_cfg_we)
                shadow_limit = i_cfg_data;
        end
        o_pending <= results_due.size();
    end

endmodule

FILE: sim/tb_bounded_positional_list.sv
// ----------------------------------------------------------------------------
// tb_bounded_positional_list
// drives directed and random list requests in bursts under a range of
// capacity limits; a checker beside the block predicts and compares results
// ----------------------------------------------------------------------------
module tb_bounded_positional_list;
    timeunit 1ns;
    timeprecision 1ps;

    import bpl_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 110;

    // codes with no operation behind them
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_request           req_bus = '0;
    logic               cfg_we = 1'b0;
    logic [LIMIT_W-1:0] cfg_data = '0;
    logic               done;
    t_result            result;

    int fails;
    int checked;
    int pending;
    int sent = 0;
    int limit_writes = 0;
    int per_cmd [8] = '{default: 0};
    int burst_left = 0;
    bit steady = 1'b0;
    int wd_cycles;

    logic [LIMIT_W-1:0] limit_plan [PHASES] = '{16, 0, 31, 1, 8, 17, 3, 16, 12, 2};

    bounded_positional_list dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (req_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_done     (done),
        .o_result   (result)
    );

    bpl_list_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req_bus),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_done       (done),
        .i_result     (result),
        .o_fail_count (fails),
        .o_checked    (checked),
        .o_pending    (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic t_request make_req(logic [CMD_W-1:0] cmd, int idx,
                                          logic [WIDTH-1:0] val);
        t_request r;
        r.command = cmd;
        r.index   = POS_W'(idx);
        r.value   = val;
        return r;
    endfunction

    // grow phases favor push and insert, shrink phases favor erase and pop
    function automatic t_request random_req(bit shrink);
        t_request r;
        int       roll;
        int       cut [6];
        if (shrink)
            cut = '{15, 25, 50, 75, 92, 95};
        else
            cut = '{35, 60, 70, 80, 95, 97};
        roll = $urandom_range(0, 99);
        r.value = $urandom;
        if ($urandom_range(0, 9) == 0)
            r.index = POS_W'($urandom_range(0, 31));
        else
            r.index = POS_W'($urandom_range(0, DEPTH));
        if (roll < cut[0])
            r.command = CMD_PUSH;
        else if (roll < cut[1])
            r.command = CMD_INSERT;
        else if (roll < cut[2])
            r.command = CMD_ERASE;
        else if (roll < cut[3])
            r.command = CMD_POP;
        else if (roll < cut[4])
            r.command = CMD_READ;
        else if (roll < cut[5])
            r.command = CMD_CLEAR;
        else
            r.command = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        return r;
    endfunction

    task automatic send(t_request r);
        start   <= 1'b1;
        req_bus <= r;
        do @(posedge clk); while (busy);
        sent++;
        per_cmd[r.command]++;
        if (!steady && burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // the checker's pending count is registered, so step the clock before polling
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] lim);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= lim;
        @(posedge clk);
        cfg_we <= 1'b0;
        limit_writes++;
    endtask

    initial begin
        for (wd_cycles = 0; wd_cycles < CYCLE_LIMIT; wd_cycles++)
            @(posedge clk);
        $display("tb_bounded_positional_list: errors");
        $finish;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty list, index edges, shifting in both directions
        write_limit(LIMIT_W'(DEPTH));
        send(make_req(CMD_POP, 0, '0));
        send(make_req(CMD_ERASE, 0, '0));
        send(make_req(CMD_READ, 0, '0));
        send(make_req(CMD_INSERT, 1, 32'h1234_5678));
        send(make_req(CMD_INSERT, 0, 32'hFFFF_FFFF));
        send(make_req(CMD_PUSH, 0, 32'h0000_0000));
        send(make_req(CMD_INSERT, 2, 32'hA5A5_A5A5));
        send(make_req(CMD_INSERT, 0, 32'h5A5A_5A5A));
        send(make_req(CMD_READ, 3, '0));
        send(make_req(CMD_READ, 4, '0));
        send(make_req(CMD_READ, 31, '0));
        send(make_req(CMD_ERASE, 4, '0));
        send(make_req(CMD_ERASE, 1, '0));
        send(make_req(CMD_SPARE_LO, 31, 32'hFFFF_FFFF));
        send(make_req(CMD_SPARE_HI, 0, 32'h8000_0001));
        send(make_req(CMD_CLEAR, 0, '0));

        // full check comes before the index check
        write_limit(LIMIT_W'(2));
        send(make_req(CMD_PUSH, 0, 32'h0000_0001));
        send(make_req(CMD_PUSH, 0, 32'h0000_0002));
        send(make_req(CMD_PUSH, 0, 32'h0000_0003));
        send(make_req(CMD_INSERT, 0, 32'h0000_0004));
        send(make_req(CMD_INSERT, 31, 32'h0000_0005));

        // limit dropped under the count: entries stay, growth is refused
        write_limit(LIMIT_W'(1));
        send(make_req(CMD_PUSH, 0, 32'h0000_0006));
        send(make_req(CMD_ERASE, 0, '0));
        send(make_req(CMD_PUSH, 0, 32'h0000_0007));
        send(make_req(CMD_POP, 0, '0));
        send(make_req(CMD_PUSH, 0, 32'h0000_0008));

        for (int p = 0; p < PHASES; p++) begin
            write_limit(limit_plan[p]);
            steady = (p % 4 == 2);
            repeat (ITEMS_PER_PHASE)
                send(random_req(p[0]));
        end

        drain();
        repeat (4) @(posedge clk);

        $display("run covered %0d requests under %0d limit settings, %0d results checked",
                 sent, limit_writes, checked);
        $display("mix: insert %0d erase %0d push %0d pop %0d read %0d clear %0d spare %0d",
                 per_cmd[CMD_INSERT], per_cmd[CMD_ERASE], per_cmd[CMD_PUSH],
                 per_cmd[CMD_POP], per_cmd[CMD_READ], per_cmd[CMD_CLEAR],
                 per_cmd[CMD_SPARE_LO] + per_cmd[CMD_SPARE_HI]);
        if (fails == 0 && pending == 0) begin
            $display("tb_bounded_positional_list: clean");
        end else begin
            $display("tb_bounded_positional_list: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/bpl_pkg.sv
design/bpl_cell.sv
design/bounded_positional_list.sv
sim/bpl_list_checker.sv
sim/tb_bounded_positional_list.sv
